// ----- rtl/zz_pkg.sv -----
// ----------------------------------------------------------------------------
// zz_pkg
// Shared types, constants and helpers for the zigzag scan address generator.
// ----------------------------------------------------------------------------
package zz_pkg;

	// Field widths
	localparam int MAX_DIM   = 1024;
	localparam int COORD_W   = $clog2(MAX_DIM);
	localparam int DIM_W     = COORD_W + 1;
	localparam int POS_W     = 20;
	localparam int KEEP_W    = POS_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = KEEP_W;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT   = 2'd2;

	// Reset values of the configuration registers
	localparam logic [DIM_W-1:0]  RST_BLOCK_WIDTH  = DIM_W'(8);
	localparam logic [DIM_W-1:0]  RST_BLOCK_HEIGHT = DIM_W'(8);
	localparam logic [KEEP_W-1:0] RST_KEEP_COUNT   = KEEP_W'(64);

	// Walk state
	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               down_left;
		logic               bounced;
		logic [POS_W-1:0]   position;
	} zz_state_t;

	// One emitted scan position
	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [POS_W-1:0]   scan_index;
		logic               keep;
		logic               is_last;
	} zz_result_t;

	// Limit a programmed dimension to 2..MAX_DIM
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v < DIM_W'(2))
			return DIM_W'(2);
		else if (v > DIM_W'(MAX_DIM))
			return DIM_W'(MAX_DIM);
		else
			return v;
	endfunction

endpackage

// ----- rtl/zz_step.sv -----
// ----------------------------------------------------------------------------
// zz_step
// One zigzag step: emits the current position and computes the next state.
// ----------------------------------------------------------------------------
module zz_step (
	input  zz_pkg::zz_state_t          cur,
	input  logic                       restart,
	input  logic [zz_pkg::DIM_W-1:0]   width,
	input  logic [zz_pkg::DIM_W-1:0]   height,
	input  logic [zz_pkg::KEEP_W-1:0]  keep_count,
	output zz_pkg::zz_result_t         result,
	output zz_pkg::zz_state_t          nxt
);
	import zz_pkg::*;

	logic               origin;
	logic [COORD_W-1:0] r, c;
	logic               dl, bl;
	logic [POS_W-1:0]   p;
	logic [COORD_W-1:0] w_m1, h_m1;
	logic               last, left, top, right, bottom, bounce;
	logic               row_inc, row_dec, col_inc, col_dec;
	logic [DIM_W-1:0]   nr, nc;
	logic               leaves;

	always_comb begin
		// Back to the origin on restart or when the position fell outside
		origin = restart || ({1'b0, cur.row} >= height) || ({1'b0, cur.col} >= width);
		r  = origin ? '0 : cur.row;
		c  = origin ? '0 : cur.col;
		dl = origin ? 1'b0 : cur.down_left;
		bl = origin ? 1'b0 : cur.bounced;
		p  = origin ? '0 : cur.position;

		w_m1 = COORD_W'(width - DIM_W'(1));
		h_m1 = COORD_W'(height - DIM_W'(1));

		left   = (c == '0);
		top    = (r == '0);
		right  = (c == w_m1);
		bottom = (r == h_m1);
		last   = bottom && right;

		result.row        = r;
		result.col        = c;
		result.scan_index = p;
		result.keep       = ({1'b0, p} < keep_count);
		result.is_last    = last;

		// Move selection: bounce along an edge or step on the diagonal
		bounce  = (left || top || right || bottom) && !bl;
		row_inc = 1'b0;
		row_dec = 1'b0;
		col_inc = 1'b0;
		col_dec = 1'b0;
		if (bounce) begin
			if (top && !right)
				col_inc = 1'b1;
			else if (left && !bottom)
				row_inc = 1'b1;
			else if (right)
				row_inc = 1'b1;
			else
				col_inc = 1'b1;
		end else if (dl) begin
			col_dec = 1'b1;
			row_inc = 1'b1;
		end else begin
			col_inc = 1'b1;
			row_dec = 1'b1;
		end

		// A decrement below zero wraps high and fails the bound check
		nr = row_inc ? ({1'b0, r} + DIM_W'(1)) :
		     row_dec ? ({1'b0, r} - DIM_W'(1)) : {1'b0, r};
		nc = col_inc ? ({1'b0, c} + DIM_W'(1)) :
		     col_dec ? ({1'b0, c} - DIM_W'(1)) : {1'b0, c};
		leaves = (nr >= height) || (nc >= width);

		// Next state: wrap after the last corner or an illegal move
		if (last || leaves) begin
			nxt = '0;
		end else begin
			nxt.row       = nr[COORD_W-1:0];
			nxt.col       = nc[COORD_W-1:0];
			nxt.down_left = bounce ? !dl : dl;
			nxt.bounced   = bounce;
			nxt.position  = p + POS_W'(1);
		end
	end

endmodule

// ----- rtl/zz_skid.sv -----
// ----------------------------------------------------------------------------
// zz_skid
// Output register with a skid entry; ready depends only on local state.
// ----------------------------------------------------------------------------
module zz_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  zz_pkg::zz_result_t  push_data,
	output logic                pop_valid,
	input  logic                pop_ready,
	output zz_pkg::zz_result_t  pop_data
);
	import zz_pkg::*;

	logic       out_valid_q, skid_valid_q;
	zz_result_t out_q, skid_q;
	logic       push, pop;

	assign push_ready = !skid_valid_q;
	assign push       = push_valid && push_ready;
	assign pop        = out_valid_q && pop_ready;
	assign pop_valid  = out_valid_q;
	assign pop_data   = out_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!out_valid_q || pop)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (push) begin
			if (!out_valid_q || pop)
				out_q <= push_data;
			else
				skid_q <= push_data;
		end
	end

endmodule

// ----- rtl/zigzag_scan_address_generator.sv -----
// Results are registered in the output entry, or in the skid entry while
// the output entry holds one. Throughput: one request per cycle while the
// skid entry is free; the walk state register closes a loop through the
// step logic, and a two-entry output buffer keeps the input side open
// while a result waits. Reset: walk returns to the origin heading
// up-right; registers reset to width 8, height 8, keep count 64.
// ----------------------------------------------------------------------------
// zigzag_scan_address_generator
// Emits (row, col, scan index, keep, last) along a diagonal zigzag walk.
// ----------------------------------------------------------------------------
module zigzag_scan_address_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [zz_pkg::COORD_W-1:0]    row,
	output logic [zz_pkg::COORD_W-1:0]    col,
	output logic [zz_pkg::POS_W-1:0]      scan_index,
	output logic                          keep,
	output logic                          is_last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [zz_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [zz_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import zz_pkg::*;

	logic [DIM_W-1:0]  block_width_q, block_height_q;
	logic [KEEP_W-1:0] keep_count_q;
	logic [DIM_W-1:0]  w, h;
	zz_state_t         state_q, state_nxt;
	zz_result_t        step_res, out_res;
	logic              in_acc;

	assign cfg_ready = 1'b1;
	assign w         = clamp_dim(block_width_q);
	assign h         = clamp_dim(block_height_q);
	assign in_acc    = in_valid && in_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_width_q  <= RST_BLOCK_WIDTH;
			block_height_q <= RST_BLOCK_HEIGHT;
			keep_count_q   <= RST_KEEP_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BLOCK_WIDTH:  block_width_q  <= cfg_data[DIM_W-1:0];
				CFG_BLOCK_HEIGHT: block_height_q <= cfg_data[DIM_W-1:0];
				CFG_KEEP_COUNT:   keep_count_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Step logic
	zz_step u_step (
		.cur        (state_q),
		.restart    (restart),
		.width      (w),
		.height     (h),
		.keep_count (keep_count_q),
		.result     (step_res),
		.nxt        (state_nxt)
	);

	// Walk state advances once per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= '0;
		else if (in_acc)
			state_q <= state_nxt;
	end

	// Result buffer
	zz_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (step_res),
		.pop_valid  (out_valid),
		.pop_ready  (out_ready),
		.pop_data   (out_res)
	);

	assign row        = out_res.row;
	assign col        = out_res.col;
	assign scan_index = out_res.scan_index;
	assign keep       = out_res.keep;
	assign is_last    = out_res.is_last;

	// Input stalls only while the output side is full
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending result");

	// A restart request emits the origin, so the walk stands at index one
	a_restart_advances: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && restart |=> state_q.position == POS_W'(1))
		else $error("walk did not advance from origin after restart");

	// After an accepted request the output always holds a valid result in the next cycle
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid)
		else $error("accepted request produced no result");

endmodule

// ----- dv/zigzag_scan_address_generator_tb.sv -----
// ----------------------------------------------------------------------------
// zigzag_scan_address_generator_tb
// Self-checking bench for the zigzag scan address generator. Step requests
// and register writes go in through valid/ready handshakes with random gaps
// on both sides. A local copy of the walk predicts every scan position, and
// each emitted position is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module zigzag_scan_address_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import zz_pkg::*;

	// Index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

	// Clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Block ports
	logic                 in_valid  = 1'b0;
	logic                 restart   = 1'b0;
	logic                 out_ready = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;
	logic                 in_ready;
	logic                 out_valid;
	logic                 cfg_ready;
	logic [COORD_W-1:0]   row;
	logic [COORD_W-1:0]   col;
	logic [POS_W-1:0]     scan_index;
	logic                 keep;
	logic                 is_last;

	zigzag_scan_address_generator i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.row        (row),
		.col        (col),
		.scan_index (scan_index),
		.keep       (keep),
		.is_last    (is_last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Predicted register contents
	logic [DIM_W-1:0]  geom_width  = RST_BLOCK_WIDTH;
	logic [DIM_W-1:0]  geom_height = RST_BLOCK_HEIGHT;
	logic [KEEP_W-1:0] keep_limit  = RST_KEEP_COUNT;

	// Predicted walk state
	int walk_row       = 0;
	int walk_col       = 0;
	bit walk_down_left = 1'b0;
	bit walk_bounced   = 1'b0;
	int walk_pos       = 0;

	// Scan positions still owed by the block, oldest first
	zz_result_t pending_scan_q[$];

	int fail_count   = 0;
	int steps_sent   = 0;
	bit sender_quiet   = 1'b0;
	bit receiver_quiet = 1'b0;
	int hold_len     = 0;

	// Programmed dimension as the walk sees it
	function automatic int dim_limit(input logic [DIM_W-1:0] v);
		return (v < 2) ? 2 : ((v > MAX_DIM) ? MAX_DIM : int'(v));
	endfunction

	function automatic void walk_home();
		walk_row       = 0;
		walk_col       = 0;
		walk_down_left = 1'b0;
		walk_bounced   = 1'b0;
		walk_pos       = 0;
	endfunction

	// Emit the current position and advance the predicted walk by one step
	function automatic zz_result_t next_scan_position(input logic rst_walk);
		int w, h, nr, nc;
		bit on_left, on_top, on_right, on_bottom;
		zz_result_t res;
		w = dim_limit(geom_width);
		h = dim_limit(geom_height);
		if (rst_walk || walk_row >= h || walk_col >= w) begin
			walk_home();
		end
		res.row        = COORD_W'(walk_row);
		res.col        = COORD_W'(walk_col);
		res.scan_index = POS_W'(walk_pos);
		res.keep       = (walk_pos < int'(keep_limit));
		res.is_last    = (walk_row == h - 1) && (walk_col == w - 1);
		if (res.is_last) begin
			walk_home();
			return res;
		end
		on_left   = (walk_col == 0);
		on_top    = (walk_row == 0);
		on_right  = (walk_col == w - 1);
		on_bottom = (walk_row == h - 1);
		nr = walk_row;
		nc = walk_col;
		// Bounce off an edge unless the last step was already a bounce
		if ((on_left || on_top || on_right || on_bottom) && !walk_bounced) begin
			if (on_top && !on_right)
				nc++;
			else if (on_left && !on_bottom)
				nr++;
			else if (on_right)
				nr++;
			else
				nc++;
			walk_down_left = !walk_down_left;
			walk_bounced   = 1'b1;
		end else begin
			if (walk_down_left) begin
				nc--;
				nr++;
			end else begin
				nc++;
				nr--;
			end
			walk_bounced = 1'b0;
		end
		// A move out of a reshaped block falls back to the origin
		if (nr < 0 || nc < 0 || nr >= h || nc >= w) begin
			walk_home();
		end else begin
			walk_row = nr;
			walk_col = nc;
			walk_pos = (walk_pos + 1) % (1 << POS_W);
		end
		return res;
	endfunction

	// Idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Dimension word, biased to small blocks, with random unused upper bits
	function automatic logic [CFG_DAT_W-1:0] pick_dim_word();
		int r;
		logic [DIM_W-1:0] v;
		logic [CFG_DAT_W-DIM_W-1:0] hi;
		r = $urandom_range(0, 99);
		if (r < 8)
			v = DIM_W'($urandom_range(0, 1));
		else if (r < 60)
			v = DIM_W'($urandom_range(2, 8));
		else if (r < 85)
			v = DIM_W'($urandom_range(9, 24));
		else if (r < 92)
			v = DIM_W'($urandom_range(25, 64));
		else if (r < 96)
			v = DIM_W'($urandom_range(1025, 2047));
		else
			v = DIM_W'(MAX_DIM);
		hi = (CFG_DAT_W-DIM_W)'($urandom());
		return {hi, v};
	endfunction

	task automatic flag_error(input string what, input zz_result_t want,
			input zz_result_t got);
		if (fail_count < 10) begin
			$display("%0t ns %s: expected row %0d col %0d index %0d keep %0b last %0b",
				$time, what, want.row, want.col, want.scan_index, want.keep,
				want.is_last);
			$display("    got row %0d col %0d index %0d keep %0b last %0b",
				got.row, got.col, got.scan_index, got.keep, got.is_last);
		end
		fail_count++;
	endtask

	// Offer one step request; book its expected position once accepted
	task automatic send_step(input logic rst_walk);
		int gap;
		gap = sender_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rst_walk;
		do @(posedge clk); while (!in_ready);
		pending_scan_q.push_back(next_scan_position(rst_walk));
		steps_sent++;
	endtask

	// Register write request; only issued while nothing is pending
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_BLOCK_WIDTH: begin
				geom_width = data[DIM_W-1:0];
			end
			CFG_BLOCK_HEIGHT: begin
				geom_height = data[DIM_W-1:0];
			end
			CFG_KEEP_COUNT: begin
				keep_limit = data[KEEP_W-1:0];
			end
			default: begin
			end
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering and wait for every owed position
	task automatic finish_pending();
		if (in_valid)
			in_valid <= 1'b0;
		while (pending_scan_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Field extremes, clamping, reshaping mid-walk, spare index
	task automatic test_directed();
		// reset geometry, then shrink the block under the walk
		send_step(1'b1);
		repeat (4) send_step(1'b0);
		finish_pending();
		write_reg(CFG_BLOCK_WIDTH, 21'd2);
		send_step(1'b0);
		// lowest dimension words act as 2, nothing kept
		finish_pending();
		write_reg(CFG_BLOCK_WIDTH, 21'd0);
		write_reg(CFG_BLOCK_HEIGHT, 21'd1);
		write_reg(CFG_KEEP_COUNT, 21'd0);
		send_step(1'b1);
		repeat (4) send_step(1'b0);
		send_step(1'b1);
		// land on the right edge after a bounce, then reshape so the
		// next diagonal move leaves the block
		finish_pending();
		write_reg(CFG_BLOCK_WIDTH, 21'd2);
		write_reg(CFG_BLOCK_HEIGHT, 21'd8);
		write_reg(CFG_KEEP_COUNT, 21'd3);
		send_step(1'b1);
		repeat (4) send_step(1'b0);
		finish_pending();
		write_reg(CFG_BLOCK_WIDTH, 21'd3);
		write_reg(CFG_BLOCK_HEIGHT, 21'd3);
		repeat (2) send_step(1'b0);
		// oversized dimension words, every position kept, spare index
		finish_pending();
		write_reg(CFG_BLOCK_WIDTH, 21'h1FFFFF);
		write_reg(CFG_BLOCK_HEIGHT, 21'h1FF401);
		write_reg(CFG_KEEP_COUNT, 21'h1FFFFF);
		write_reg(CFG_SPARE_IDX, 21'h0AAAAA);
		send_step(1'b1);
		repeat (2) send_step(1'b0);
	endtask

	// Full rate on both sides
	task automatic test_back_to_back();
		finish_pending();
		write_reg(CFG_BLOCK_WIDTH, 21'd5);
		write_reg(CFG_BLOCK_HEIGHT, 21'd4);
		write_reg(CFG_KEEP_COUNT, 21'd10);
		sender_quiet   = 1'b1;
		receiver_quiet = 1'b1;
		send_step(1'b1);
		repeat (59) send_step(1'b0);
		finish_pending();
		sender_quiet   = 1'b0;
		receiver_quiet = 1'b0;
	endtask

	// Long output hold-off while requests keep coming, then a full drain
	task automatic test_output_stall();
		finish_pending();
		write_reg(CFG_BLOCK_WIDTH, 21'd6);
		write_reg(CFG_BLOCK_HEIGHT, 21'd6);
		write_reg(CFG_KEEP_COUNT, 21'd20);
		hold_len     = 50;
		sender_quiet = 1'b1;
		@(posedge clk);
		send_step(1'b1);
		repeat (29) send_step(1'b0);
		sender_quiet = 1'b0;
		finish_pending();
		repeat (20) send_step(1'b0);
	endtask

	// Random geometry phases; the walk carries over between phases
	task automatic test_random_walks();
		int start, n, restart_pct;
		logic [CFG_DAT_W-1:0] k;
		start = steps_sent;
		while (steps_sent - start < 280) begin
			finish_pending();
			if ($urandom_range(0, 9) < 7)
				write_reg(CFG_BLOCK_WIDTH, pick_dim_word());
			if ($urandom_range(0, 9) < 7)
				write_reg(CFG_BLOCK_HEIGHT, pick_dim_word());
			if ($urandom_range(0, 9) < 6) begin
				case ($urandom_range(0, 6))
					0: k = '0;
					1: k = 21'd1;
					2: k = CFG_DAT_W'($urandom_range(0, 64));
					3: k = CFG_DAT_W'(dim_limit(geom_width) * dim_limit(geom_height));
					4: k = 21'h100000;
					5: k = '1;
					default: k = CFG_DAT_W'($urandom());
				endcase
				write_reg(CFG_KEEP_COUNT, k);
			end
			// mostly clean walks, sometimes restart noise
			restart_pct    = ($urandom_range(0, 4) == 0) ? 30 : 2;
			sender_quiet   = ($urandom_range(0, 6) == 0);
			receiver_quiet = sender_quiet;
			n = $urandom_range(10, 60);
			repeat (n) send_step($urandom_range(0, 99) < restart_pct);
		end
		sender_quiet   = 1'b0;
		receiver_quiet = 1'b0;
	endtask

	// Widest and tallest blocks, walked along their long edges
	task automatic test_large_blocks();
		finish_pending();
		write_reg(CFG_BLOCK_WIDTH, 21'd1024);
		write_reg(CFG_BLOCK_HEIGHT, 21'd2);
		write_reg(CFG_KEEP_COUNT, 21'd50);
		send_step(1'b1);
		repeat (79) send_step(1'b0);
		finish_pending();
		write_reg(CFG_BLOCK_WIDTH, 21'd2);
		write_reg(CFG_BLOCK_HEIGHT, 21'd1024);
		send_step(1'b1);
		repeat (79) send_step(1'b0);
	endtask

	// Output ready: random stalls, quiet stretches, requested hold-offs
	initial begin : drive_out_ready
		int stall_cnt, stall;
		stall_cnt = 0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				stall_cnt = hold_len - 1;
				hold_len  = 0;
				out_ready <= 1'b0;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
				out_ready <= 1'b0;
			end else if (receiver_quiet) begin
				out_ready <= 1'b1;
			end else begin
				stall = pick_gap();
				if (stall == 0) begin
					out_ready <= 1'b1;
				end else begin
					stall_cnt = stall - 1;
					out_ready <= 1'b0;
				end
			end
		end
	end

	// Compare each accepted scan position with the oldest prediction
	always @(posedge clk) begin : check_scan
		zz_result_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {row, col, scan_index, keep, is_last};
			if (pending_scan_q.size() == 0) begin
				flag_error("result with nothing pending", '0, got);
			end else begin
				want = pending_scan_q.pop_front();
				if (got.row !== want.row || got.col !== want.col ||
						got.scan_index !== want.scan_index ||
						got.keep !== want.keep || got.is_last !== want.is_last) begin
					flag_error("wrong scan position", want, got);
				end
			end
		end
	end

	// Test sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_back_to_back();
		test_output_stall();
		test_random_walks();
		test_large_blocks();
		finish_pending();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_scan_q.size() == 0) begin
			$display("zigzag_scan_address_generator: match");
		end else begin
			$display("zigzag_scan_address_generator: mismatch");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#30ms;
		$display("zigzag_scan_address_generator: mismatch");
		$finish;
	end

endmodule
